[rtl/sstq_pkg.sv]
// Package for the sorted sleep timer queue.
// Holds the word types of both channels, the status codes and the sequencer states.
// No dependencies.
package sstq_pkg;

  // Width of the tick counter and of every stored wake tick.
  localparam int TICK_W = 63;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  // Input kinds.
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_SLEEP = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_TICK     = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Input word.
  typedef struct packed {
    logic               kind;
    logic [5:0]         thread_id;
    logic signed [31:0] sleep_ticks;
  } in_word_t;

  // Result word.
  typedef struct packed {
    status_t           status;
    logic              woke;
    logic [5:0]        woken_id;
    logic [TICK_W-1:0] tick_value;
    logic              last;
  } out_word_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_REPLY,
    S_INS_RD,
    S_INS_CMP,
    S_REL_RD,
    S_REL_CMP
  } state_t;

endpackage

[rtl/sstq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module sstq_ram #(
  parameter int WIDTH = 69,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data registered every cycle.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/sorted_sleep_timer_queue.sv]
// Sorted sleep timer queue: tick counter plus a wake-ordered queue of sleepers in a RAM ring.
// Sleep: a rejected request is answered without a queue walk; otherwise each queued entry with a
// later wake tick is read, compared and moved one slot towards the tail, and the new sleeper is
// written behind the first entry with an earlier or equal wake tick. Tick: an empty queue is answered
// without a walk; otherwise entries are released from the head, one RAM read and compare each. Output stalls add on.
// One input word at a time; the next is taken once the last result is in the output register.
// Reset (synchronous, rst_n low) clears the counter, queue and output; no clearing pass.
// Depends on sstq_pkg and sstq_ram.
module sorted_sleep_timer_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_BITS     = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sstq_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sstq_pkg::out_word_t  out_word
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = PW + CW;
  localparam int TW = sstq_pkg::TICK_W;
  localparam int EW = TW + ID_BITS;

  // Ring position of queue slot k counted from the head.
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] h, input logic [CW-1:0] k);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(k);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return s[PW-1:0];
  endfunction

  sstq_pkg::state_t    state_r, state_nxt;
  logic [TW-1:0]       tick_r, tick_nxt;
  logic [TW-1:0]       wake_r, wake_nxt;
  logic [ID_BITS-1:0]  id_r, id_nxt;
  logic [PW-1:0]       head_r, head_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       slot_r, slot_nxt;
  sstq_pkg::status_t   reply_r, reply_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [ID_BITS-1:0]  pend_id_r, pend_id_nxt;
  logic                out_valid_r, out_valid_nxt;
  sstq_pkg::out_word_t out_word_r, out_word_nxt;

  logic                wr_en;
  logic [PW-1:0]       wr_addr;
  logic [EW-1:0]       wr_data;
  logic [PW-1:0]       rd_addr;
  logic [EW-1:0]       rd_data;

  logic                accept;
  logic                out_free;
  logic                ignore;
  logic                full;
  logic [TW:0]         wake_sum;
  logic [TW-1:0]       wake_sat;
  logic [TW-1:0]       rd_wake;
  logic [ID_BITS-1:0]  rd_id;
  logic                rel_hit;
  logic                ins_stop;
  logic [CW-1:0]       rd_slot;
  logic                emit;
  sstq_pkg::out_word_t emit_word;

  // Queue storage: wake tick above, thread id below.
  sstq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshake terms.
  assign in_ready  = (state_r == sstq_pkg::S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Request checks and the saturating wake tick.
  assign ignore   = in_word.sleep_ticks[31] || (in_word.sleep_ticks == 32'sd0);
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign wake_sum = {1'b0, tick_r} + {{(TW - 30){1'b0}}, in_word.sleep_ticks[30:0]};
  assign wake_sat = wake_sum[TW] ? sstq_pkg::TICK_MAX : wake_sum[TW-1:0];

  // The comparators work on the word just read from the RAM.
  assign rd_wake  = rd_data[EW-1:ID_BITS];
  assign rd_id    = rd_data[ID_BITS-1:0];
  assign rel_hit  = (rd_wake <= tick_r);
  assign ins_stop = (rd_wake <= wake_r);

  // Insertion walks from the tail down; release always reads the head.
  assign rd_slot = (slot_r == '0) ? '0 : slot_r - CW'(1);
  assign rd_addr = ((state_r == sstq_pkg::S_INS_RD) || (state_r == sstq_pkg::S_INS_CMP)) ?
                   phys(head_r, rd_slot) : head_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sstq_pkg::S_IDLE: begin
        if (accept) begin
          if (in_word.kind == sstq_pkg::KIND_TICK) begin
            state_nxt = sstq_pkg::S_REL_RD;
          end else if (ignore || full) begin
            state_nxt = sstq_pkg::S_REPLY;
          end else begin
            state_nxt = sstq_pkg::S_INS_RD;
          end
        end
      end
      sstq_pkg::S_REPLY: begin
        if (out_free) begin
          state_nxt = sstq_pkg::S_IDLE;
        end
      end
      sstq_pkg::S_INS_RD: begin
        state_nxt = (slot_r == '0) ? sstq_pkg::S_REPLY : sstq_pkg::S_INS_CMP;
      end
      sstq_pkg::S_INS_CMP: begin
        state_nxt = ins_stop ? sstq_pkg::S_REPLY : sstq_pkg::S_INS_RD;
      end
      sstq_pkg::S_REL_RD: begin
        if (count_r != '0) begin
          state_nxt = sstq_pkg::S_REL_CMP;
        end else if (out_free) begin
          state_nxt = sstq_pkg::S_IDLE;
        end
      end
      sstq_pkg::S_REL_CMP: begin
        if (rel_hit) begin
          if (!pend_valid_r || out_free) begin
            state_nxt = sstq_pkg::S_REL_RD;
          end
        end else if (out_free) begin
          state_nxt = sstq_pkg::S_IDLE;
        end
      end
      default: state_nxt = sstq_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    tick_nxt       = tick_r;
    wake_nxt       = wake_r;
    id_nxt         = id_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    slot_nxt       = slot_r;
    reply_nxt      = reply_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    wr_en          = 1'b0;
    wr_addr        = phys(head_r, slot_r);
    wr_data        = {wake_r, id_r};
    emit           = 1'b0;
    emit_word      = '{status:     sstq_pkg::ST_TICK,
                       woke:       1'b0,
                       woken_id:   6'd0,
                       tick_value: tick_r,
                       last:       1'b1};
    unique case (state_r)
      sstq_pkg::S_IDLE: begin
        if (accept) begin
          if (in_word.kind == sstq_pkg::KIND_TICK) begin
            if (tick_r != sstq_pkg::TICK_MAX) begin
              tick_nxt = tick_r + TW'(1);
            end
            pend_valid_nxt = 1'b0;
          end else if (ignore) begin
            reply_nxt = sstq_pkg::ST_IGNORED;
          end else if (full) begin
            reply_nxt = sstq_pkg::ST_FULL;
          end else begin
            wake_nxt  = wake_sat;
            id_nxt    = ID_BITS'(in_word.thread_id);
            slot_nxt  = count_r;
            reply_nxt = sstq_pkg::ST_ACCEPTED;
          end
        end
      end
      sstq_pkg::S_REPLY: begin
        if (out_free) begin
          emit             = 1'b1;
          emit_word.status = reply_r;
        end
      end
      sstq_pkg::S_INS_RD: begin
        // Queue empty below this slot: the new sleeper goes at the head.
        if (slot_r == '0) begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      sstq_pkg::S_INS_CMP: begin
        wr_en = 1'b1;
        if (ins_stop) begin
          count_nxt = count_r + CW'(1);
        end else begin
          // Later wake tick: move the entry one slot towards the tail.
          wr_data  = rd_data;
          slot_nxt = slot_r - CW'(1);
        end
      end
      sstq_pkg::S_REL_RD: begin
        if ((count_r == '0) && out_free) begin
          emit               = 1'b1;
          emit_word.woke     = pend_valid_r;
          emit_word.woken_id = pend_valid_r ? 6'(pend_id_r) : 6'd0;
          pend_valid_nxt     = 1'b0;
        end
      end
      sstq_pkg::S_REL_CMP: begin
        if (rel_hit) begin
          // Hold the released id back until we know whether it is the last one.
          if (!pend_valid_r || out_free) begin
            if (pend_valid_r) begin
              emit               = 1'b1;
              emit_word.woke     = 1'b1;
              emit_word.woken_id = 6'(pend_id_r);
              emit_word.last     = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = rd_id;
            head_nxt       = phys(head_r, CW'(1));
            count_nxt      = count_r - CW'(1);
          end
        end else if (out_free) begin
          emit               = 1'b1;
          emit_word.woke     = pend_valid_r;
          emit_word.woken_id = pend_valid_r ? 6'(pend_id_r) : 6'd0;
          pend_valid_nxt     = 1'b0;
        end
      end
      default: begin
        pend_valid_nxt = 1'b0;
      end
    endcase
  end

  // Output register.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_word_nxt  = emit_word;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
      out_word_nxt  = out_word_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sstq_pkg::S_IDLE;
      tick_r       <= '0;
      head_r       <= '0;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_r       <= tick_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    wake_r     <= wake_nxt;
    id_r       <= id_nxt;
    slot_r     <= slot_nxt;
    reply_r    <= reply_nxt;
    pend_id_r  <= pend_id_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Testbench for sorted_sleep_timer_queue: directed and random sleep and tick words,
// with a scoreboard that models the tick counter and the wake-ordered sleeper queue.
// Depends on sstq_pkg and the block's RTL.
module testbench;

  localparam int QUEUE_DEPTH  = 16;
  localparam int ID_BITS      = 6;
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int PHASE_ITEMS  = 48;

  // Scoreboard: its own copy of the counter and the sleeper queue.
  class sleep_queue_scoreboard;
    logic [sstq_pkg::TICK_W-1:0] ticks;
    logic [sstq_pkg::TICK_W-1:0] wake_at[QUEUE_DEPTH];
    logic [5:0]                  owner[QUEUE_DEPTH];
    int unsigned                 used;
    sstq_pkg::out_word_t         expected_q[$];
    int errors;
    int words_in;
    int results_seen;
    int released;
    int full_seen;
    int ignored_seen;

    function new();
      ticks        = '0;
      used         = 0;
      errors       = 0;
      words_in     = 0;
      results_seen = 0;
      released     = 0;
      full_seen    = 0;
      ignored_seen = 0;
    endfunction

    function void push_result(sstq_pkg::status_t s, logic w, logic [5:0] id, logic fin);
      sstq_pkg::out_word_t e;
      e.status     = s;
      e.woke       = w;
      e.woken_id   = id;
      e.tick_value = ticks;
      e.last       = fin;
      expected_q.push_back(e);
    endfunction

    // Works out the results of one accepted input word.
    function void note_input(sstq_pkg::in_word_t w);
      logic [sstq_pkg::TICK_W-1:0] dur;
      logic [sstq_pkg::TICK_W-1:0] wake;
      int unsigned pos;
      int unsigned n;
      int unsigned i;
      words_in++;
      if (w.kind == sstq_pkg::KIND_SLEEP) begin
        if (w.sleep_ticks == 0 || w.sleep_ticks[31]) begin
          ignored_seen++;
          push_result(sstq_pkg::ST_IGNORED, 1'b0, 6'd0, 1'b1);
        end else if (used >= QUEUE_DEPTH) begin
          full_seen++;
          push_result(sstq_pkg::ST_FULL, 1'b0, 6'd0, 1'b1);
        end else begin
          dur  = {31'd0, w.sleep_ticks};
          wake = (ticks > sstq_pkg::TICK_MAX - dur) ? sstq_pkg::TICK_MAX : ticks + dur;
          // A new sleeper goes behind every entry with the same wake tick.
          pos = 0;
          while (pos < used && wake_at[pos] <= wake) pos++;
          for (i = used; i > pos; i--) begin
            wake_at[i] = wake_at[i-1];
            owner[i]   = owner[i-1];
          end
          wake_at[pos] = wake;
          owner[pos]   = w.thread_id;
          used++;
          push_result(sstq_pkg::ST_ACCEPTED, 1'b0, 6'd0, 1'b1);
        end
      end else begin
        if (ticks != sstq_pkg::TICK_MAX) ticks++;
        n = 0;
        while (n < used && wake_at[n] <= ticks) n++;
        if (n == 0) begin
          push_result(sstq_pkg::ST_TICK, 1'b0, 6'd0, 1'b1);
        end else begin
          for (i = 0; i < n; i++)
            push_result(sstq_pkg::ST_TICK, 1'b1, owner[i], i + 1 == n);
          for (i = n; i < used; i++) begin
            wake_at[i-n] = wake_at[i];
            owner[i-n]   = owner[i];
          end
          used -= n;
          released += n;
        end
      end
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t: mismatch on %s, expected %0h, got %0h", $time, field, want, got);
      errors++;
    endfunction

    // Compares one result word with the oldest expectation.
    function void check_result(sstq_pkg::out_word_t got);
      sstq_pkg::out_word_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: result word with nothing expected, got %0h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.status != e.status) report("status", e.status, got.status);
      if (got.woke != e.woke) report("woke", e.woke, got.woke);
      if (got.woken_id != e.woken_id) report("woken_id", e.woken_id, got.woken_id);
      if (got.tick_value != e.tick_value)
        report("tick_value", e.tick_value, got.tick_value);
      if (got.last != e.last) report("last", e.last, got.last);
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  sstq_pkg::in_word_t  in_word   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  sstq_pkg::out_word_t out_word;

  int   tx_idle_pct  = 0;
  int   rx_stall_pct = 0;
  logic hold_req     = 1'b0;
  logic hold_done    = 1'b0;
  int   hold_left    = 0;
  int   quiet        = 0;

  sleep_queue_scoreboard sb = new();

  sorted_sleep_timer_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  // Clock, 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Handshake monitor: notes accepted words, checks results and watches for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_input(in_word);
      if (out_valid && out_ready) sb.check_result(out_word);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet = quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic sstq_pkg::in_word_t make_word(logic k, logic [5:0] id, logic [31:0] dur);
    sstq_pkg::in_word_t w;
    w.kind        = k;
    w.thread_id   = id;
    w.sleep_ticks = dur;
    return w;
  endfunction

  // Mostly short sleeps so that sleepers wake often; some far off, some rejected.
  function automatic sstq_pkg::in_word_t random_word(int tick_pct);
    sstq_pkg::in_word_t w;
    int r;
    w.kind        = sstq_pkg::KIND_SLEEP;
    w.thread_id   = 6'($urandom_range(63));
    w.sleep_ticks = $urandom;
    if ($urandom_range(99) < tick_pct) begin
      w.kind = sstq_pkg::KIND_TICK;
    end else begin
      r = $urandom_range(99);
      if (r < 8)       w.sleep_ticks = $urandom | 32'h8000_0000;
      else if (r < 12) w.sleep_ticks = 32'd0;
      else if (r < 14) w.sleep_ticks = $urandom_range(32'h7fff_ffff, 1);
      else if (r < 32) w.sleep_ticks = $urandom_range(300, 9);
      else             w.sleep_ticks = $urandom_range(8, 1);
    end
    return w;
  endfunction

  // Offers one word after a random idle stretch and waits until it is taken.
  task automatic send_word(sstq_pkg::in_word_t w);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops in_valid and lets the monitor sample first so that the word just taken is already in the scoreboard.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    int i;
    int ph;
    int tick_pct;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty tick, rejected durations at the extremes, equal wake ticks.
    send_word(make_word(sstq_pkg::KIND_TICK, 6'd63, 32'hffff_ffff));
    send_word(make_word(sstq_pkg::KIND_SLEEP, 6'd0, 32'd0));
    send_word(make_word(sstq_pkg::KIND_SLEEP, 6'd63, 32'hffff_ffff));
    send_word(make_word(sstq_pkg::KIND_SLEEP, 6'd5, 32'h8000_0000));
    send_word(make_word(sstq_pkg::KIND_SLEEP, 6'd10, 32'd2));
    send_word(make_word(sstq_pkg::KIND_SLEEP, 6'd11, 32'd2));
    send_word(make_word(sstq_pkg::KIND_SLEEP, 6'd12, 32'd1));
    send_word(make_word(sstq_pkg::KIND_TICK, 6'd0, 32'd0));
    send_word(make_word(sstq_pkg::KIND_TICK, 6'd0, 32'd0));
    // Fill the queue, overflow it, then release all sixteen on one tick.
    for (i = 0; i < QUEUE_DEPTH; i++)
      send_word(make_word(sstq_pkg::KIND_SLEEP,
                          (i == QUEUE_DEPTH - 1) ? 6'd63 : 6'(i * 4), 32'd1));
    send_word(make_word(sstq_pkg::KIND_SLEEP, 6'd33, 32'd7));
    send_word(make_word(sstq_pkg::KIND_TICK, 6'd0, 32'd0));
    // The longest sleep never wakes within the run.
    send_word(make_word(sstq_pkg::KIND_SLEEP, 6'd42, 32'h7fff_ffff));
    wait_all_results();

    // Random words across the idling phases.
    for (ph = 0; ph < 4; ph++) begin
      tx_idle_pct  <= (ph == 1) ? 58 : (ph == 3) ? 22 : 0;
      rx_stall_pct <= (ph == 2) ? 58 : (ph == 3) ? 22 : 0;
      tick_pct = $urandom_range(55, 35);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 0 && i == 20) hold_req <= 1'b1;
        send_word(random_word(tick_pct));
      end
      wait_all_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d words, %0d results, %0d sleepers woken, %0d full, %0d ignored.",
             sb.words_in, sb.results_seen, sb.released, sb.full_seen, sb.ignored_seen);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results still expected", sb.errors, sb.expected_q.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
